// ----- hdl/utfvr_pkg.sv -----
package utfvr_pkg;

  // longest run of result bytes one input byte can cause
  localparam int RunDepth = 6;
  localparam int RunCntW  = $clog2(RunDepth + 1);

  // replacement character U+FFFD
  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  // lead bytes and bounds that restrict the first continuation
  localparam logic [7:0] LeadMin2  = 8'hC2;
  localparam logic [7:0] LeadMax4  = 8'hF4;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] ContMinE0 = 8'hA0;
  localparam logic [7:0] ContMaxED = 8'h9F;
  localparam logic [7:0] ContMinF0 = 8'h90;
  localparam logic [7:0] ContMaxF4 = 8'h8F;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  // pending sequence
  typedef struct packed {
    logic [2:0][7:0] held;
    logic [1:0]      cnt;
    logic [1:0]      need;
  } dec_state_t;

  // result bytes of one input byte, lowest index goes out first
  typedef struct packed {
    logic [RunDepth-1:0][7:0] bytes;
    logic [RunCntW-1:0]       cnt;
  } run_t;

  function automatic lead_e lead_class(input logic [7:0] c);
    lead_e k;
    if (c[7] == 1'b0) begin
      k = LEAD_ASCII;
    end else if (c[7:5] == 3'b110 && c >= LeadMin2) begin
      k = LEAD_TWO;
    end else if (c[7:4] == 4'b1110) begin
      k = LEAD_THREE;
    end else if (c[7:3] == 5'b11110 && c <= LeadMax4) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_BAD;
    end
    return k;
  endfunction

  function automatic logic first_cont_ok(input logic [7:0] lead, input logic [7:0] c);
    logic ok;
    ok = 1'b1;
    if (lead == LeadE0 && c < ContMinE0) ok = 1'b0;
    if (lead == LeadED && c > ContMaxED) ok = 1'b0;
    if (lead == LeadF0 && c < ContMinF0) ok = 1'b0;
    if (lead == LeadMax4 && c > ContMaxF4) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- hdl/utfvr_step.sv -----
module utfvr_step
  import utfvr_pkg::*;
(
  input  dec_state_t st_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output dec_state_t st_o,
  output run_t       run_o
);

  logic               cont_ok;
  logic               take_lead;
  logic [RunCntW-1:0] n;

  assign cont_ok = (byte_i[7:6] == 2'b10) &&
                   ((st_i.cnt != 2'd1) || first_cont_ok(st_i.held[0], byte_i));

  always_comb begin
    st_o       = st_i;
    run_o      = '0;
    n          = '0;
    take_lead  = 1'b0;

    if (st_i.cnt != 2'd0) begin
      if (cont_ok) begin
        if (st_i.cnt >= st_i.need) begin
          // sequence complete, pass it through
          for (int i = 0; i < 3; i++) begin
            if (i < int'(st_i.cnt)) begin
              run_o.bytes[n] = st_i.held[i];
              n = n + 1'b1;
            end
          end
          run_o.bytes[n] = byte_i;
          n = n + 1'b1;
          st_o.cnt  = 2'd0;
          st_o.need = 2'd0;
        end else begin
          st_o.held[st_i.cnt] = byte_i;
          st_o.cnt            = st_i.cnt + 2'd1;
        end
      end else begin
        // maximal subpart replaced, byte retried as a lead
        run_o.bytes[n] = ReplByte0; n = n + 1'b1;
        run_o.bytes[n] = ReplByte1; n = n + 1'b1;
        run_o.bytes[n] = ReplByte2; n = n + 1'b1;
        st_o.cnt  = 2'd0;
        st_o.need = 2'd0;
        take_lead = 1'b1;
      end
    end else begin
      take_lead = 1'b1;
    end

    if (take_lead) begin
      unique case (lead_class(byte_i))
        LEAD_ASCII: begin
          run_o.bytes[n] = byte_i;
          n = n + 1'b1;
        end
        LEAD_TWO: begin
          st_o.held[0] = byte_i;
          st_o.cnt     = 2'd1;
          st_o.need    = 2'd1;
        end
        LEAD_THREE: begin
          st_o.held[0] = byte_i;
          st_o.cnt     = 2'd1;
          st_o.need    = 2'd2;
        end
        LEAD_FOUR: begin
          st_o.held[0] = byte_i;
          st_o.cnt     = 2'd1;
          st_o.need    = 2'd3;
        end
        default: begin
          run_o.bytes[n] = ReplByte0; n = n + 1'b1;
          run_o.bytes[n] = ReplByte1; n = n + 1'b1;
          run_o.bytes[n] = ReplByte2; n = n + 1'b1;
        end
      endcase
    end

    if (end_i) begin
      // flush a sequence cut short by the end of the stream
      if (st_o.cnt != 2'd0) begin
        run_o.bytes[n] = ReplByte0; n = n + 1'b1;
        run_o.bytes[n] = ReplByte1; n = n + 1'b1;
        run_o.bytes[n] = ReplByte2; n = n + 1'b1;
      end
      st_o.cnt  = 2'd0;
      st_o.need = 2'd0;
    end

    run_o.cnt = n;
  end

endmodule

// ----- hdl/utf8_validate_replace.sv -----
// utf8 sanitizer with maximal-subpart replacement
//
// slave channel: one raw byte per transfer on s_axis_tdata, s_axis_tlast
// marks the final byte of a stream. master channel: one sanitized byte per
// transfer, m_axis_tuser flags the last byte caused by one input byte and
// m_axis_tlast flags the final byte of the stream.
//
// a byte accepted on the slave side sits in the input register, is decoded
// into the run buffer once that buffer is free and is offered on the master
// side from then on. a byte that is held as part of a pending sequence gives
// no output at all.
// the master side sends one byte per cycle while m_axis_tready is high. an
// input byte that causes k result bytes (up to six) holds the run buffer until
// all k have left; the next byte moves in as the last one leaves, so the input
// side takes one byte per cycle while each gives at most one result byte and the receiver does not stall.
// when the receiver stalls, the run buffer holds, then the input register
// fills and s_axis_tready drops. reset empties both and clears the pending
// sequence; after a byte with tlast the decoder is idle again.
module utf8_validate_replace
  import utfvr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tuser,   // last_in_run
  output logic       m_axis_tlast    // stream_end
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // decoder state
  dec_state_t st_q, st_d;

  // run buffer, shifted down by one byte per master transfer
  logic [RunDepth-1:0][7:0] run_bytes_q, run_bytes_d;
  logic [RunCntW-1:0]       run_cnt_q, run_cnt_d;
  logic                     run_end_q, run_end_d;

  run_t step_run;
  logic s_xfer, m_xfer, run_free, move;

  utfvr_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .st_o   (st_d),
    .run_o  (step_run)
  );

  assign m_axis_tvalid = (run_cnt_q != '0);
  assign m_axis_tdata  = run_bytes_q[0];
  assign m_axis_tuser  = (run_cnt_q == RunCntW'(1));
  assign m_axis_tlast  = (run_cnt_q == RunCntW'(1)) && run_end_q;

  assign m_xfer   = m_axis_tvalid && m_axis_tready;
  // buffer is free now or its last byte leaves in this cycle
  assign run_free = (run_cnt_q == '0) || (m_xfer && run_cnt_q == RunCntW'(1));
  assign move     = in_valid_q && run_free;

  assign s_axis_tready = !in_valid_q || move;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    run_bytes_d = run_bytes_q;
    run_cnt_d   = run_cnt_q;
    run_end_d   = run_end_q;

    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end

    if (move) begin
      // decoded run replaces whatever is left (at most the leaving byte)
      run_bytes_d = step_run.bytes;
      run_cnt_d   = step_run.cnt;
      run_end_d   = in_end_q;
    end else if (m_xfer) begin
      for (int k = 0; k < RunDepth - 1; k++) begin
        run_bytes_d[k] = run_bytes_q[k+1];
      end
      run_cnt_d = run_cnt_q - RunCntW'(1);
    end
  end

  // held bytes of the pending sequence are not reset, only its counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      run_cnt_q  <= '0;
      st_q.cnt   <= 2'd0;
      st_q.need  <= 2'd0;
    end else begin
      in_valid_q <= in_valid_d;
      run_cnt_q  <= run_cnt_d;
      if (move) begin
        st_q <= st_d;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
    run_bytes_q <= run_bytes_d;
    run_end_q   <= run_end_d;
  end

  // a stalled result keeps its byte count
  a_run_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (run_cnt_q == $past(run_cnt_q)))
    else $error("run buffer changed while stalled");

  // an input byte waiting for the run buffer is not dropped
  a_input_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !run_free) |=> (in_valid_q && in_byte_q == $past(in_byte_q)))
    else $error("input register lost a waiting byte");

  // end of stream only on the last byte of a run
  a_end_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> (m_axis_tvalid && m_axis_tuser))
    else $error("stream end outside the last byte of a run");

  // run never exceeds its depth
  a_run_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q <= RunCntW'(RunDepth))
    else $error("run count beyond buffer depth");

endmodule
